[rtl/core/meli_pkg.sv]
package meli_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned NUM_W  = 4;
  // packed result data: number, six 16-bit spans, padded to whole bytes
  localparam int unsigned RES_DATA_W = NUM_W + 6 * POS_W;
  localparam int unsigned M_TDATA_W  = ((RES_DATA_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;
  localparam logic [BYTE_W-1:0] CH_TWO  = 8'h32;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

  // one input beat
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;
  } item_t;

  // one result beat
  typedef struct packed {
    logic              record_valid;
    logic [NUM_W-1:0]  entry_number;
    logic [POS_W-1:0]  entry_offset;
    logic [POS_W-1:0]  entry_len;
    logic [POS_W-1:0]  sleep_offset;
    logic [POS_W-1:0]  sleep_len;
    logic [POS_W-1:0]  color_offset;
    logic [POS_W-1:0]  color_len;
    logic              file_done;
  } result_t;

endpackage

[rtl/core/menu_entry_line_indexer.sv]
// channel | dir | beat contents
// s       | in  | tdata[7:0] data_byte, tlast is_last
// m       | out | tdata entry_number..color_len, tuser record_valid, tlast file_done
//
// one byte per cycle while a full output register does not hold the input back; a beat's
// result is written to the output register in the same cycle the beat leaves the input register.
// bytes that neither close an entry line nor end the file give no m beat.
// rst is synchronous, active high; parser state returns to its start values,
// and also after every beat with tlast so the next beat starts a new file.
// a full output register that is not taken stalls the input register only
// when the held byte has a result to deliver.
module menu_entry_line_indexer import meli_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [3:0] entry_number, [19:4] entry_offset, [35:20] entry_len,
  // [51:36] sleep_offset, [67:52] sleep_len, [83:68] color_offset,
  // [99:84] color_len, upper bits zero
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,   // [0] record_valid
  output logic                 m_tlast
);

  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  logic    out_free;

  // the held byte moves on unless it has a result and the output is full
  assign advance = item_valid && (!res_valid || out_free);

  meli_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  meli_parser #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  meli_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/core/meli_in_stage.sv]
module meli_in_stage import meli_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [BYTE_W-1:0]   s_tdata,
  input  logic                s_tlast,
  input  logic                advance,
  output logic                item_valid,
  output item_t               item
);

  // take a new beat when empty or when the held one moves on this cycle
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.data_byte <= s_tdata;
      item.is_last   <= s_tlast;
    end
  end

endmodule

[rtl/core/meli_parser.sv]
module meli_parser import meli_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    advance,
  output logic    res_valid,
  output result_t res
);

  // entry counter must reach MAX_ENTRIES and show at least four bits
  localparam int unsigned CNT_RAW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CNT_W   = (CNT_RAW < NUM_W) ? NUM_W : CNT_RAW;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [POS_W-1:0]  line_base, line_base_next;
  logic [BYTE_W-1:0] first_char, first_char_next;
  logic [BYTE_W-1:0] second_char, second_char_next;
  logic              skip_after_cr, skip_after_cr_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [POS_W-1:0]  sleep_start, sleep_start_next;
  logic [POS_W-1:0]  sleep_len, sleep_len_next;
  logic [POS_W-1:0]  color_start, color_start_next;
  logic [POS_W-1:0]  color_len, color_len_next;
  logic              parse_stopped, parse_stopped_next;

  logic [POS_W-1:0]  off;
  logic [BYTE_W-1:0] first_eff;
  logic [BYTE_W-1:0] second_eff;
  logic              is_cr;
  logic              is_term;
  logic [POS_W-1:0]  span_start;
  logic [POS_W-1:0]  span_len;
  logic [CNT_W-1:0]  count_inc;
  logic              rec;

  assign off        = byte_position - line_base;
  assign first_eff  = (off == '0) ? item.data_byte : first_char;
  assign second_eff = (off == POS_W'(1)) ? item.data_byte : second_char;
  assign is_cr      = (item.data_byte == CH_CR);
  assign is_term    = is_cr || (item.data_byte == CH_LF);
  assign span_start = line_base + POS_W'(3);
  assign span_len   = (off >= POS_W'(3)) ? (off - POS_W'(3)) : '0;
  assign count_inc  = entry_count + CNT_ONE;

  always_comb begin
    byte_position_next = byte_position + POS_W'(1);
    line_base_next     = line_base;
    first_char_next    = first_char;
    second_char_next   = second_char;
    skip_after_cr_next = skip_after_cr;
    entry_count_next   = entry_count;
    sleep_start_next   = sleep_start;
    sleep_len_next     = sleep_len;
    color_start_next   = color_start;
    color_len_next     = color_len;
    parse_stopped_next = parse_stopped;
    rec                = 1'b0;
    if (!parse_stopped) begin
      if (skip_after_cr) begin
        // byte after a cr is dropped unseen
        skip_after_cr_next = 1'b0;
        line_base_next     = byte_position + POS_W'(1);
      end else begin
        if (off == '0) begin
          first_char_next = item.data_byte;
        end else if (off == POS_W'(1)) begin
          second_char_next = item.data_byte;
        end
        if (is_term) begin
          if (!(is_cr && item.is_last)) begin
            if (first_eff == CH_HASH) begin
              if (second_eff == CH_ONE) begin
                sleep_start_next = span_start;
                sleep_len_next   = span_len;
              end else if (second_eff == CH_TWO) begin
                color_start_next = span_start;
                color_len_next   = span_len;
              end
            end else begin
              rec              = 1'b1;
              entry_count_next = count_inc;
              if (count_inc >= CNT_MAX) begin
                parse_stopped_next = 1'b1;
              end
            end
          end
          if (is_cr) begin
            skip_after_cr_next = 1'b1;
          end else begin
            line_base_next = byte_position + POS_W'(1);
          end
        end
      end
    end
    // end of file brings everything back to the reset values
    if (item.is_last) begin
      byte_position_next = '0;
      line_base_next     = '0;
      first_char_next    = '0;
      second_char_next   = '0;
      skip_after_cr_next = 1'b0;
      entry_count_next   = CNT_ONE;
      sleep_start_next   = '0;
      sleep_len_next     = '0;
      color_start_next   = '0;
      color_len_next     = '0;
      parse_stopped_next = 1'b0;
    end
  end

  always_comb begin
    res           = '0;
    res_valid     = rec || item.is_last;
    res.file_done = item.is_last;
    if (rec) begin
      res.record_valid = 1'b1;
      res.entry_number = entry_count[NUM_W-1:0];
      res.entry_offset = line_base;
      res.entry_len    = off;
      res.sleep_offset = sleep_start;
      res.sleep_len    = sleep_len;
      res.color_offset = color_start;
      res.color_len    = color_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      line_base     <= '0;
      first_char    <= '0;
      second_char   <= '0;
      skip_after_cr <= 1'b0;
      entry_count   <= CNT_ONE;
      sleep_start   <= '0;
      sleep_len     <= '0;
      color_start   <= '0;
      color_len     <= '0;
      parse_stopped <= 1'b0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      line_base     <= line_base_next;
      first_char    <= first_char_next;
      second_char   <= second_char_next;
      skip_after_cr <= skip_after_cr_next;
      entry_count   <= entry_count_next;
      sleep_start   <= sleep_start_next;
      sleep_len     <= sleep_len_next;
      color_start   <= color_start_next;
      color_len     <= color_len_next;
      parse_stopped <= parse_stopped_next;
    end
  end

  a_no_record_when_stopped: assert property (@(posedge clk) disable iff (rst)
    parse_stopped |-> !rec)
    else $error("record produced after parse stop");

  a_last_clears_position: assert property (@(posedge clk) disable iff (rst)
    advance && item.is_last |=> byte_position == '0 && entry_count == CNT_ONE)
    else $error("state not cleared after last beat");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_MAX && entry_count != '0)
    else $error("entry counter out of range");

  a_stop_at_limit: assert property (@(posedge clk) disable iff (rst)
    parse_stopped |-> entry_count == CNT_MAX)
    else $error("parse stopped below entry limit");

endmodule

[rtl/core/meli_out_stage.sv]
module meli_out_stage import meli_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              res,
  output logic                 out_free,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  result_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      held <= res;
    end
  end

  assign m_tdata = {{(M_TDATA_W - RES_DATA_W){1'b0}},
                    held.color_len, held.color_offset,
                    held.sleep_len, held.sleep_offset,
                    held.entry_len, held.entry_offset,
                    held.entry_number};
  assign m_tuser = held.record_valid;
  assign m_tlast = held.file_done;

endmodule

[tb/sv/menu_entry_line_indexer_tb.sv]
module menu_entry_line_indexer_tb;
  import meli_pkg::*;

  localparam int unsigned MAX_ENTRIES = 16;
  // cycles with no beat on either side before the run is abandoned
  localparam int unsigned IDLE_LIMIT = 2000;
  // random part of the stimulus, in bytes
  localparam int unsigned RANDOM_BYTES = 600;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  menu_entry_line_indexer #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bytes waiting for the driver, and entry records the indexer must still produce
  item_t   file_bytes [$];
  result_t indexed_results [$];
  int unsigned mismatches = 0;

  // line indexer state as the block should hold it
  logic [POS_W-1:0]  byte_pos;
  logic [POS_W-1:0]  line_base;
  logic [BYTE_W-1:0] first_ch;
  logic [BYTE_W-1:0] second_ch;
  bit                skip_cr;
  logic [POS_W-1:0]  entry_count;
  logic [POS_W-1:0]  sleep_start;
  logic [POS_W-1:0]  sleep_len;
  logic [POS_W-1:0]  color_start;
  logic [POS_W-1:0]  color_len;
  bit                parse_stopped;

  // back to the start of a file: after reset and after every beat with tlast
  task automatic restart_index();
    byte_pos      = '0;
    line_base     = '0;
    first_ch      = '0;
    second_ch     = '0;
    skip_cr       = 1'b0;
    entry_count   = 16'd1;
    sleep_start   = '0;
    sleep_len     = '0;
    color_start   = '0;
    color_len     = '0;
    parse_stopped = 1'b0;
  endtask

  // advance the index by one accepted byte, queue the record or done beat it causes
  task automatic index_byte(input logic [BYTE_W-1:0] b, input logic ends_file);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] off;
    result_t          res;
    bit               has_record;
    pos        = byte_pos;
    res        = '0;
    has_record = 1'b0;
    if (!parse_stopped) begin
      if (skip_cr) begin
        // byte after a CR is dropped unseen, the next line starts after it
        skip_cr   = 1'b0;
        line_base = pos + 16'd1;
      end else begin
        off = pos - line_base;
        if (off == 16'd0) begin
          first_ch = b;
        end else if (off == 16'd1) begin
          second_ch = b;
        end
        if (b == CH_CR || b == CH_LF) begin
          // a CR on the last byte drops the line it would close
          if (!(b == CH_CR && ends_file)) begin
            if (first_ch == CH_HASH) begin
              // parameter span starts past "#n ", clamped to zero length when short
              if (second_ch == CH_ONE) begin
                sleep_start = line_base + 16'd3;
                sleep_len   = (off >= 16'd3) ? off - 16'd3 : '0;
              end else if (second_ch == CH_TWO) begin
                color_start = line_base + 16'd3;
                color_len   = (off >= 16'd3) ? off - 16'd3 : '0;
              end
            end else begin
              has_record         = 1'b1;
              res.record_valid   = 1'b1;
              res.entry_number   = entry_count[NUM_W-1:0];
              res.entry_offset   = line_base;
              res.entry_len      = off;
              res.sleep_offset   = sleep_start;
              res.sleep_len      = sleep_len;
              res.color_offset   = color_start;
              res.color_len      = color_len;
              entry_count        = entry_count + 16'd1;
              if (entry_count >= MAX_ENTRIES) begin
                parse_stopped = 1'b1;
              end
            end
          end
          if (b == CH_CR) begin
            skip_cr = 1'b1;
          end else begin
            line_base = pos + 16'd1;
          end
        end
      end
    end
    byte_pos = pos + 16'd1;
    if (ends_file) begin
      res.file_done = 1'b1;
      restart_index();
    end
    if (ends_file || has_record) begin
      indexed_results.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic ends_file);
    item_t beat;
    beat.data_byte = b;
    beat.is_last   = ends_file;
    file_bytes.push_back(beat);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], 1'b0);
    end
  endtask

  // whole file, tlast on its final byte
  task automatic push_file(input logic [BYTE_W-1:0] text [$]);
    foreach (text[i]) begin
      push_byte(text[i], i == text.size() - 1);
    end
  endtask

  // any byte that does not end a line
  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do begin
      b = BYTE_W'($urandom_range(0, 255));
    end while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // random byte leaning toward the ones the parser reacts to
  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_HASH;
      3: return CH_ONE;
      4: return CH_TWO;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed menu files with random content, some pure noise
  task automatic push_random_file();
    logic [BYTE_W-1:0] text [$];
    int unsigned       n;
    int unsigned       term;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 40);
      repeat (n) text.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(1, 24)) begin
        // line head: entry, sleep line, color line or comment
        case ($urandom_range(0, 9))
          6: begin
            text.push_back(CH_HASH);
            text.push_back(CH_ONE);
          end
          7: begin
            text.push_back(CH_HASH);
            text.push_back(CH_TWO);
          end
          8, 9: text.push_back(CH_HASH);
          default: ;
        endcase
        n = $urandom_range(0, 6);
        repeat (n) text.push_back(text_byte());
        // LF, CR LF, or CR with an arbitrary skipped byte
        term = $urandom_range(0, 9);
        if (term < 6) begin
          text.push_back(CH_LF);
        end else if (term < 8) begin
          text.push_back(CH_CR);
          text.push_back(CH_LF);
        end else begin
          text.push_back(CH_CR);
          text.push_back(noise_byte());
        end
      end
      // file end: clean, unterminated tail, or a line closed by CR on the last byte
      case ($urandom_range(0, 5))
        0: repeat ($urandom_range(1, 3)) text.push_back(text_byte());
        1: begin
          text.push_back(text_byte());
          text.push_back(CH_CR);
        end
        default: ;
      endcase
    end
    push_file(text);
  endtask

  // random idle length: mostly none or short, a few long, with calm stretches
  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one byte beat at a time from file_bytes, with random gaps
  // ---------------------------------------------------------------------------
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;
  item_t       send_beat;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (file_bytes.size() != 0) begin
        send_beat = file_bytes.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= send_beat.data_byte;
        s_tlast  <= send_beat.is_last;
        send_gap = pick_gap(send_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts from accepted byte beats, checks accepted result beats
  // ---------------------------------------------------------------------------
  int unsigned recv_gap  = 0;
  int unsigned recv_calm = 0;
  result_t     got;
  result_t     want;

  function automatic void check_field(input string name, input logic [POS_W-1:0] exp_val,
                                      input logic [POS_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_index();
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        index_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        got.record_valid = m_tuser;
        got.entry_number = m_tdata[3:0];
        got.entry_offset = m_tdata[19:4];
        got.entry_len    = m_tdata[35:20];
        got.sleep_offset = m_tdata[51:36];
        got.sleep_len    = m_tdata[67:52];
        got.color_offset = m_tdata[83:68];
        got.color_len    = m_tdata[99:84];
        got.file_done    = m_tlast;
        if (indexed_results.size() == 0) begin
          $error("result beat with no expected record: tdata %0h tuser %0b tlast %0b",
                 m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = indexed_results.pop_front();
          check_field("record_valid", POS_W'(want.record_valid),
                      POS_W'(got.record_valid));
          check_field("entry_number", POS_W'(want.entry_number),
                      POS_W'(got.entry_number));
          check_field("entry_offset", want.entry_offset, got.entry_offset);
          check_field("entry_len",    want.entry_len,    got.entry_len);
          check_field("sleep_offset", want.sleep_offset, got.sleep_offset);
          check_field("sleep_len",    want.sleep_len,    got.sleep_len);
          check_field("color_offset", want.color_offset, got.color_offset);
          check_field("color_len",    want.color_len,    got.color_len);
          check_field("file_done",    POS_W'(want.file_done), POS_W'(got.file_done));
          check_field("tdata padding", '0, POS_W'(m_tdata[M_TDATA_W-1:RES_DATA_W]));
        end
        recv_gap = pick_gap(recv_calm);
      end
      // stall only counts down, so low tready also meets a freshly raised tvalid
      if (recv_gap != 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no beat on either side for too long ends the run
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  int unsigned       random_start;

  initial begin
    // directed file: sleep span, short color span ended by CR LF, comment,
    // entry with extreme bytes, lone hash line, empty entries (one closed by a CR
    // whose skipped byte is a hash), then an unterminated line that is dropped
    push_text("#1 9\n");
    push_text("#2\r\n");
    push_text("#x\n");
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_text("\n#\n\n\r#");
    push_text("a");
    push_byte("b", 1'b1);
    // a line closed by CR on the last byte is dropped
    push_byte("x", 1'b0);
    push_byte(CH_CR, 1'b1);
    // a file that is a single empty line
    push_byte(CH_LF, 1'b1);

    random_start = file_bytes.size();
    while (file_bytes.size() - random_start < RANDOM_BYTES) begin
      push_random_file();
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // all bytes sent and every expected beat seen
    do begin
      @(negedge clk);
    end while (file_bytes.size() != 0 || s_tvalid || indexed_results.size() != 0);
    // then wait on to catch stray result beats
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
